// ----- sv/palette_color_effect_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PALETTE_COLOR_EFFECT_DEFINES_SVH
`define PALETTE_COLOR_EFFECT_DEFINES_SVH

// same-cycle implication
`define PCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pce_pkg.sv -----
package pce_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY     = 3'd4;

    localparam logic [2:0] MODE_TINT      = 3'd0;
    localparam logic [2:0] MODE_RANDOMIZE = 3'd1;
    localparam logic [2:0] MODE_NEGATE    = 3'd2;
    localparam logic [2:0] MODE_DODGE     = 3'd3;
    localparam logic [2:0] MODE_BURN      = 3'd4;
    localparam logic [2:0] MODE_SOFT_TINT = 3'd5;

    localparam logic [16:0] FULL_OPACITY = 17'h10000;
    localparam logic [15:0] LFSR_TAPS    = 16'hb400;
    localparam logic [15:0] NEGATE_MID   = 16'h8000;
    localparam logic [15:0] ALL_ONES     = 16'hffff;
    localparam logic [15:0] SEED_RESET   = 16'h0001;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic        last_in;
    } pce_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        last_out;
    } pce_out_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       mul1;
        logic       mul2;
        logic       fin;
        logic       push;
        logic [1:0] comp;
    } pce_cmd_t;

endpackage

// ----- sv/palette_color_effect.sv -----
// palette_color_effect: one palette entry in, one adjusted entry out.
// Each component, red then green then blue, passes through the shared multiplier
//   in the product, blend product and finish steps; then the result is handed off.
// A new item is taken only after the previous result has gone to the output register.
// Reset (rst_n, async, active low): idle, no result held, configuration registers
//   cleared, noise seed set to 1.
module palette_color_effect (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pce_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input item channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pce_pkg::pce_in_t                in_data,
    // result item channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output pce_pkg::pce_out_t               out_data
);
    import pce_pkg::*;

    pce_cmd_t cmd;

    // Controller walks red, green, blue through multiply, blend and finish
    // steps, then hands the result to the output register. A new item is
    // taken as soon as the controller is back in idle, even while the
    // previous result still waits on out_stall.
    pce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: config registers, noise LFSR (steps only in randomize mode,
    // once per component), one 16x16 multiplier, result and output registers.
    pce_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data)
    );

endmodule

// ----- sv/pce_ctrl.sv -----
module pce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pce_pkg::pce_cmd_t cmd
);
    import pce_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] comp_reg;
    logic [1:0] comp_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && in_valid;
        cmd.mul1 = (state_reg == ST_MUL1);
        cmd.mul2 = (state_reg == ST_MUL2);
        cmd.fin  = (state_reg == ST_FIN);
        cmd.push = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
        cmd.comp = comp_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL1;
                    comp_next  = COMP_RED;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:
            begin
                if (comp_reg == COMP_BLUE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL1;
                    comp_next  = comp_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (cmd.push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            comp_reg      <= COMP_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/pce_datapath.sv -----
module pce_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pce_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  pce_pkg::pce_cmd_t                 cmd,
    input  pce_pkg::pce_in_t                  in_data,
    output pce_pkg::pce_out_t                 out_data
);
    import pce_pkg::*;

    logic [2:0]         mode_reg;
    logic [15:0]        tint_red_reg;
    logic [15:0]        tint_green_reg;
    logic [15:0]        tint_blue_reg;
    logic [16:0]        opacity_reg;
    logic [15:0]        seed_reg;
    logic [15:0]        seed_next;

    pce_in_t            item_reg;
    logic [7:0]         peak_reg;
    logic [15:0]        mask_reg;
    logic [31:0]        mul1_reg;
    logic signed [26:0] blend_reg;
    logic [15:0]        res_red_reg;
    logic [15:0]        res_green_reg;
    logic [15:0]        res_blue_reg;
    pce_out_t           out_reg;

    logic [16:0]        t;
    logic [8:0]         a;
    logic [15:0]        pinned;
    logic [15:0]        mask_next;
    logic [15:0]        peak_full;
    logic [15:0]        o;
    logic [15:0]        c;
    logic [15:0]        mul_a;
    logic [15:0]        mul_b;
    logic [15:0]        target;
    logic signed [16:0] diff;
    logic [16:0]        inv;
    logic [15:0]        lfsr_step;
    logic [15:0]        x;
    logic [17:0]        neg_hi;
    logic signed [18:0] neg_lo;
    logic signed [18:0] dodge_v;
    logic [17:0]        burn_v;
    logic [15:0]        result;

    // opacity limited to full, blend weight and randomize mask
    always_comb
    begin
        t         = (opacity_reg > FULL_OPACITY) ? FULL_OPACITY : opacity_reg;
        a         = t[16:8];
        pinned    = t[16] ? ALL_ONES : t[15:0];
        mask_next = pinned;
        mask_next = mask_next | (mask_next >> 1);
        mask_next = mask_next | (mask_next >> 2);
        mask_next = mask_next | (mask_next >> 4);
        mask_next = mask_next | (mask_next >> 8);
        inv       = FULL_OPACITY - t;
    end

    always_comb
    begin
        peak_full = in_data.red_in;
        if (in_data.green_in > peak_full)
        begin
            peak_full = in_data.green_in;
        end
        if (in_data.blue_in > peak_full)
        begin
            peak_full = in_data.blue_in;
        end
    end

    always_comb
    begin
        case (cmd.comp)
            COMP_RED:
            begin
                o = item_reg.red_in;
                c = tint_red_reg;
            end
            COMP_GREEN:
            begin
                o = item_reg.green_in;
                c = tint_green_reg;
            end
            default:
            begin
                o = item_reg.blue_in;
                c = tint_blue_reg;
            end
        endcase
    end

    // shared 16x16 multiplier: soft tint scales the color, dodge and burn mix with o
    always_comb
    begin
        mul_a = (mode_reg == MODE_DODGE) ? ~c : c;
        mul_b = (mode_reg == MODE_SOFT_TINT) ? {8'h00, peak_reg} : o;
    end

    always_comb
    begin
        target = (mode_reg == MODE_SOFT_TINT) ? mul1_reg[23:8] : c;
        diff   = $signed({1'b0, target}) - $signed({1'b0, o});
    end

    always_comb
    begin
        lfsr_step = seed_reg[0] ? ((seed_reg >> 1) ^ LFSR_TAPS) : (seed_reg >> 1);
        x         = o ^ c;
        neg_hi    = {2'b00, x} + {1'b0, inv};
        neg_lo    = $signed({3'b000, x}) - $signed({2'b00, inv});
        dodge_v   = $signed({3'b000, ALL_ONES}) - $signed({3'b000, mul1_reg[31:16]})
                    - $signed({2'b00, t});
        burn_v    = {2'b00, mul1_reg[31:16]} + {1'b0, inv};

        case (mode_reg)
            MODE_TINT, MODE_SOFT_TINT:
                result = o + blend_reg[23:8];      // floor of d/256, low bits
            MODE_RANDOMIZE:
                result = o + (lfsr_step & mask_reg);
            MODE_NEGATE:
            begin
                if (o > NEGATE_MID)
                begin
                    result = (neg_hi > {2'b00, o}) ? o : neg_hi[15:0];
                end
                else
                begin
                    result = (neg_lo < $signed({3'b000, o})) ? o : neg_lo[15:0];
                end
            end
            MODE_DODGE:
                result = (dodge_v > $signed({3'b000, o})) ? o : dodge_v[15:0];
            MODE_BURN:
                result = (burn_v > {2'b00, o}) ? o : burn_v[15:0];
            default:
                result = o;
        endcase

        seed_next = seed_reg;
        if (cmd.fin && (mode_reg == MODE_RANDOMIZE))
        begin
            seed_next = lfsr_step;
        end
    end

    // control-side state: configuration and noise seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TINT;
            tint_red_reg   <= '0;
            tint_green_reg <= '0;
            tint_blue_reg  <= '0;
            opacity_reg    <= '0;
            seed_reg       <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EFFECT_MODE: mode_reg       <= cfg_data[2:0];
                    CFG_TINT_RED:    tint_red_reg   <= cfg_data[15:0];
                    CFG_TINT_GREEN:  tint_green_reg <= cfg_data[15:0];
                    CFG_TINT_BLUE:   tint_blue_reg  <= cfg_data[15:0];
                    CFG_OPACITY:     opacity_reg    <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
            peak_reg <= peak_full[15:8];
            mask_reg <= mask_next;
        end
        if (cmd.mul1)
        begin
            mul1_reg <= mul_a * mul_b;
        end
        if (cmd.mul2)
        begin
            blend_reg <= diff * $signed({1'b0, a});
        end
        if (cmd.fin)
        begin
            case (cmd.comp)
                COMP_RED:   res_red_reg   <= result;
                COMP_GREEN: res_green_reg <= result;
                default:    res_blue_reg  <= result;
            endcase
        end
        if (cmd.push)
        begin
            out_reg.red_out   <= res_red_reg;
            out_reg.green_out <= res_green_reg;
            out_reg.blue_out  <= res_blue_reg;
            out_reg.last_out  <= item_reg.last_in;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- sv/pce_checker.sv -----
`include "palette_color_effect_defines.svh"

module pce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input pce_pkg::pce_out_t out_data
);
    // a held result stays put until taken
    `PCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

    // one item at a time: busy right after an accept
    `PCE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while item in flight")

    // a fresh result never appears right after an accept
    `PCE_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared too early")

    // results are only produced while the block is working on an item
    `PCE_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result without work in flight")

endmodule

bind palette_color_effect pce_checker u_pce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
